// ===== rtl/uleb_pkg.sv =====
// Shared types, constants and ring-pointer helpers for the line edit buffer.
// No dependencies; imported by every module of the block.
package uleb_pkg;

    localparam int RX_DEPTH = 64;
    localparam int TX_DEPTH = 64;
    localparam int RX_AW = $clog2(RX_DEPTH);
    localparam int RX_CW = $clog2(RX_DEPTH + 1);
    localparam int TX_AW = $clog2(TX_DEPTH);
    localparam int TX_CW = $clog2(TX_DEPTH + 1);
    localparam int LINE_W = 7;
    localparam int LEN_W = 6;
    localparam int CFG_IDX_W = 2;

    localparam logic [LINE_W-1:0] LINE_MAX = 7'd127;
    localparam logic [RX_CW-1:0] RX_FULL = RX_CW'(RX_DEPTH);
    localparam logic [TX_CW-1:0] TX_FULL = TX_CW'(TX_DEPTH);

    // item kinds
    localparam logic [2:0] KIND_RX = 3'd0;
    localparam logic [2:0] KIND_TX_TICK = 3'd1;
    localparam logic [2:0] KIND_PUT = 3'd2;
    localparam logic [2:0] KIND_GET_LINE = 3'd3;
    localparam logic [2:0] KIND_CLEAR = 3'd4;

    // result codes
    localparam logic [2:0] CODE_ACK = 3'd0;
    localparam logic [2:0] CODE_TX_BYTE = 3'd1;
    localparam logic [2:0] CODE_LINE_BYTE = 3'd2;
    localparam logic [2:0] CODE_LINE_END = 3'd3;
    localparam logic [2:0] CODE_NO_LINE = 3'd4;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DELIMITER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKSPACE = 2'd1;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]       code;
        logic [7:0]       out_byte;
        logic             accepted;
        logic [LEN_W-1:0] line_length;
        logic             last;
    } out_item_t;

    typedef struct packed {
        logic load_item;
        logic do_single;
        logic scan_start;
        logic scan_step;
        logic scan_miss;
        logic emit_start;
        logic emit_byte;
        logic emit_end;
        logic sel_scan;
    } cmd_t;

    typedef struct packed {
        logic       out_free;
        logic [2:0] kind;
        logic       no_line;
        logic       scan_done;
        logic       delim_hit;
        logic       emit_done;
    } status_t;

    function automatic logic [RX_AW-1:0] rx_inc(input logic [RX_AW-1:0] p);
        return (p == RX_AW'(RX_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [RX_AW-1:0] rx_dec(input logic [RX_AW-1:0] p);
        return (p == '0) ? RX_AW'(RX_DEPTH - 1) : p - 1'b1;
    endfunction

    function automatic logic [TX_AW-1:0] tx_inc(input logic [TX_AW-1:0] p);
        return (p == TX_AW'(TX_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

// ===== rtl/uleb_ctrl.sv =====
// Sequencer for the line edit buffer: steps each word through execute,
// line scan and line emit. Depends on uleb_pkg.
module uleb_ctrl
    import uleb_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t status,
    output cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_SCMP = 3'd3;
    localparam logic [2:0] ST_ERD = 3'd4;
    localparam logic [2:0] ST_EWR = 3'd5;

    logic [2:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (status.out_free) begin
                    if (status.kind == KIND_GET_LINE && !status.no_line) begin
                        cmd.scan_start = 1'b1;
                        state_next = ST_SCAN;
                    end else begin
                        cmd.do_single = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SCAN: begin
                cmd.sel_scan = 1'b1;
                if (status.scan_done) begin
                    if (status.out_free) begin
                        cmd.scan_miss = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else begin
                    state_next = ST_SCMP;
                end
            end
            ST_SCMP: begin
                cmd.sel_scan = 1'b1;
                if (status.delim_hit) begin
                    cmd.emit_start = 1'b1;
                    state_next = ST_ERD;
                end else begin
                    cmd.scan_step = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_ERD: begin
                if (status.emit_done) begin
                    if (status.out_free) begin
                        cmd.emit_end = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else begin
                    state_next = ST_EWR;
                end
            end
            ST_EWR: begin
                if (status.out_free) begin
                    cmd.emit_byte = 1'b1;
                    state_next = ST_ERD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/uleb_dp.sv =====
// Datapath of the line edit buffer: receive and transmit rings, pointers,
// line counter, config registers and the result register. Depends on uleb_pkg.
module uleb_dp
    import uleb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  in_item_t             s_data,
    input  logic                 cfg_wr,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    input  cmd_t                 cmd,
    output status_t              status,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data
);

    logic [7:0] rx_mem [RX_DEPTH];
    logic [7:0] tx_mem [TX_DEPTH];

    logic [7:0]        delim_reg, delim_next;
    logic [7:0]        bs_reg, bs_next;
    in_item_t          item_reg;
    logic [RX_AW-1:0]  rx_wp_reg, rx_wp_next;
    logic [RX_AW-1:0]  rx_rp_reg, rx_rp_next;
    logic [RX_CW-1:0]  rx_fill_reg, rx_fill_next;
    logic [LINE_W-1:0] line_cnt_reg, line_cnt_next;
    logic [TX_AW-1:0]  tx_wp_reg, tx_wp_next;
    logic [TX_AW-1:0]  tx_rp_reg, tx_rp_next;
    logic [TX_CW-1:0]  tx_fill_reg, tx_fill_next;
    logic [RX_AW-1:0]  scan_pos_reg, scan_pos_next;
    logic [RX_CW-1:0]  scan_cnt_reg, scan_cnt_next;
    logic [RX_CW-1:0]  emit_cnt_reg, emit_cnt_next;
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_data_reg, m_data_next;
    logic [7:0]        rx_rd_reg, tx_rd_reg;

    logic             rx_we, tx_we;
    logic [RX_AW-1:0] rx_raddr;
    logic             out_free, tx_has_room;

    assign out_free = !m_valid_reg || m_ready;
    assign tx_has_room = tx_fill_reg != TX_FULL;
    assign rx_raddr = cmd.sel_scan ? scan_pos_reg : rx_rp_reg;

    assign status.out_free = out_free;
    assign status.kind = item_reg.kind;
    assign status.no_line = line_cnt_reg == '0;
    assign status.scan_done = scan_cnt_reg == rx_fill_reg;
    assign status.delim_hit = rx_rd_reg == delim_reg;
    assign status.emit_done = emit_cnt_reg == scan_cnt_reg;

    always_comb begin
        delim_next = delim_reg;
        bs_next = bs_reg;
        rx_wp_next = rx_wp_reg;
        rx_rp_next = rx_rp_reg;
        rx_fill_next = rx_fill_reg;
        line_cnt_next = line_cnt_reg;
        tx_wp_next = tx_wp_reg;
        tx_rp_next = tx_rp_reg;
        tx_fill_next = tx_fill_reg;
        scan_pos_next = scan_pos_reg;
        scan_cnt_next = scan_cnt_reg;
        emit_cnt_next = emit_cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next = m_data_reg;
        rx_we = 1'b0;
        tx_we = 1'b0;

        if (cfg_wr) begin
            if (cfg_index == CFG_DELIMITER) begin
                delim_next = cfg_data;
            end else if (cfg_index == CFG_BACKSPACE) begin
                bs_next = cfg_data;
            end
        end

        if (cmd.do_single) begin
            m_valid_next = 1'b1;
            m_data_next = '0;
            m_data_next.code = CODE_ACK;
            m_data_next.last = 1'b1;
            case (item_reg.kind)
                KIND_RX: begin
                    if (rx_fill_reg != RX_FULL) begin
                        m_data_next.accepted = 1'b1;
                        // echo first, dropped when tx ring is full
                        if (tx_has_room) begin
                            tx_we = 1'b1;
                            tx_wp_next = tx_inc(tx_wp_reg);
                            tx_fill_next = tx_fill_reg + 1'b1;
                        end
                        if (item_reg.data_byte == bs_reg) begin
                            if (rx_fill_reg != '0) begin
                                rx_fill_next = rx_fill_reg - 1'b1;
                                rx_wp_next = rx_dec(rx_wp_reg);
                            end
                        end else begin
                            rx_we = 1'b1;
                            rx_wp_next = rx_inc(rx_wp_reg);
                            rx_fill_next = rx_fill_reg + 1'b1;
                            if (item_reg.data_byte == delim_reg && line_cnt_reg != LINE_MAX) begin
                                line_cnt_next = line_cnt_reg + 1'b1;
                            end
                        end
                    end
                end
                KIND_TX_TICK: begin
                    if (tx_fill_reg != '0) begin
                        m_data_next.code = CODE_TX_BYTE;
                        m_data_next.out_byte = tx_rd_reg;
                        tx_rp_next = tx_inc(tx_rp_reg);
                        tx_fill_next = tx_fill_reg - 1'b1;
                    end
                end
                KIND_PUT: begin
                    if (tx_has_room) begin
                        m_data_next.accepted = 1'b1;
                        tx_we = 1'b1;
                        tx_wp_next = tx_inc(tx_wp_reg);
                        tx_fill_next = tx_fill_reg + 1'b1;
                    end
                end
                KIND_GET_LINE: begin
                    // only reached with no complete line pending
                    m_data_next.code = CODE_NO_LINE;
                end
                KIND_CLEAR: begin
                    m_data_next.accepted = 1'b1;
                    rx_wp_next = '0;
                    rx_rp_next = '0;
                    rx_fill_next = '0;
                    line_cnt_next = '0;
                end
                default: begin
                end
            endcase
        end

        if (cmd.scan_start) begin
            scan_pos_next = rx_rp_reg;
            scan_cnt_next = '0;
        end

        if (cmd.scan_step) begin
            scan_pos_next = rx_inc(scan_pos_reg);
            scan_cnt_next = scan_cnt_reg + 1'b1;
        end

        // stale line count: drop all stored bytes, keep the count
        if (cmd.scan_miss) begin
            rx_rp_next = rx_wp_reg;
            rx_fill_next = '0;
            m_valid_next = 1'b1;
            m_data_next = '0;
            m_data_next.code = CODE_NO_LINE;
            m_data_next.last = 1'b1;
        end

        if (cmd.emit_start) begin
            emit_cnt_next = '0;
        end

        if (cmd.emit_byte) begin
            rx_rp_next = rx_inc(rx_rp_reg);
            emit_cnt_next = emit_cnt_reg + 1'b1;
            m_valid_next = 1'b1;
            m_data_next = '0;
            m_data_next.code = CODE_LINE_BYTE;
            m_data_next.out_byte = rx_rd_reg;
        end

        // skip the delimiter itself
        if (cmd.emit_end) begin
            rx_rp_next = rx_inc(rx_rp_reg);
            rx_fill_next = rx_fill_reg - scan_cnt_reg - 1'b1;
            line_cnt_next = line_cnt_reg - 1'b1;
            m_valid_next = 1'b1;
            m_data_next = '0;
            m_data_next.code = CODE_LINE_END;
            m_data_next.line_length = LEN_W'(scan_cnt_reg);
            m_data_next.last = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delim_reg <= 8'd13;
            bs_reg <= 8'd8;
            rx_wp_reg <= '0;
            rx_rp_reg <= '0;
            rx_fill_reg <= '0;
            line_cnt_reg <= '0;
            tx_wp_reg <= '0;
            tx_rp_reg <= '0;
            tx_fill_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            delim_reg <= delim_next;
            bs_reg <= bs_next;
            rx_wp_reg <= rx_wp_next;
            rx_rp_reg <= rx_rp_next;
            rx_fill_reg <= rx_fill_next;
            line_cnt_reg <= line_cnt_next;
            tx_wp_reg <= tx_wp_next;
            tx_rp_reg <= tx_rp_next;
            tx_fill_reg <= tx_fill_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_reg <= s_data;
        end
        scan_pos_reg <= scan_pos_next;
        scan_cnt_reg <= scan_cnt_next;
        emit_cnt_reg <= emit_cnt_next;
        m_data_reg <= m_data_next;
    end

    // ring memories, registered read
    always_ff @(posedge aclk) begin
        if (rx_we) begin
            rx_mem[rx_wp_reg] <= item_reg.data_byte;
        end
        rx_rd_reg <= rx_mem[rx_raddr];
    end

    always_ff @(posedge aclk) begin
        if (tx_we) begin
            tx_mem[tx_wp_reg] <= item_reg.data_byte;
        end
        tx_rd_reg <= tx_mem[tx_rp_reg];
    end

    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

    a_rx_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rx_fill_reg <= RX_FULL)
        else $error("rx fill count exceeds ring depth");

    a_tx_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        tx_fill_reg <= TX_FULL)
        else $error("tx fill count exceeds ring depth");

    a_emit_in_line: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_byte |-> (emit_cnt_reg < scan_cnt_reg && line_cnt_reg != '0))
        else $error("line byte emitted beyond scanned line");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.do_single || cmd.scan_miss || cmd.emit_byte || cmd.emit_end) |-> out_free)
        else $error("result register overwritten while still held");

endmodule

// ===== rtl/uart_line_edit_buffer.sv =====
// Top level of the UART line edit buffer: joins sequencer and datapath.
// Depends on uleb_pkg, uleb_ctrl, uleb_dp.
//
//  channel   handshake             payload
//  s_        s_valid / s_ready     s_data    (in_item_t: kind, data_byte)
//  m_        m_valid / m_ready     m_data    (out_item_t: code, out_byte, ...)
//  cfg_      cfg_valid / cfg_ready cfg_index, cfg_data (always ready)
//
// A single-result word is accepted, then executed into the result register once that is free.
// get_line is accepted and decoded, scans the receive ring up to and including the delimiter,
// emits each line byte and then the end word; each scanned byte passes SCAN then SCMP, each emitted
// byte ERD then EWR, since the receive ring has a single read port with registered data.
// A stale line count scans every stored byte before its no_line word.
// Reset is synchronous; the rings need no clearing pass, pointers and counts clear at once.
// A low m_ready holds the sequencer at its next result; s_ready is high only when idle.
module uart_line_edit_buffer
    import uleb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    uleb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    uleb_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ===== dv/uart_line_edit_buffer_test.sv =====
// Self-checking testbench for uart_line_edit_buffer: a line-editing model predicts every
// result word, a checker compares them in order. Depends on uleb_pkg and the block's RTL.
module uart_line_edit_buffer_test;
    import uleb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_PCT = 38;
    localparam logic [7:0] DELIM_RESET = 8'd13;
    localparam logic [7:0] BS_RESET = 8'd8;
    localparam logic [7:0] CEIL_DELIM = 8'h0A;
    localparam logic [7:0] CEIL_OTHER = 8'h0B;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    in_item_t             s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    out_item_t            m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_data = '0;

    uart_line_edit_buffer u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // line editor state as the block should hold it
    logic [7:0] delim = DELIM_RESET;
    logic [7:0] bs = BS_RESET;
    logic [7:0] rx_ring [RX_DEPTH];
    logic [7:0] tx_ring [TX_DEPTH];
    int rx_wr = 0, rx_rd = 0, rx_cnt = 0, lines = 0;
    int tx_wr = 0, tx_rd = 0, tx_cnt = 0;

    out_item_t expected_words[$];
    int failures = 0;
    int item_count = 0;
    int cycle_count = 0;
    bit steady = 1'b0;
    int hold_asked = 0;
    int hold_served = 0;
    int hold_left = 0;

    function automatic int rx_next(input int p);
        return (p + 1 >= RX_DEPTH) ? 0 : p + 1;
    endfunction

    function automatic int tx_next(input int p);
        return (p + 1 >= TX_DEPTH) ? 0 : p + 1;
    endfunction

    function automatic void add_word(input logic [2:0] code, input logic [7:0] value,
                                     input logic acc, input logic [LEN_W-1:0] len,
                                     input logic fin);
        out_item_t r;
        r.code = code;
        r.out_byte = value;
        r.accepted = acc;
        r.line_length = len;
        r.last = fin;
        expected_words.push_back(r);
    endfunction

    function automatic bit echo_push(input logic [7:0] value);
        if (tx_cnt >= TX_DEPTH) return 1'b0;
        tx_ring[tx_wr] = value;
        tx_wr = tx_next(tx_wr);
        tx_cnt++;
        return 1'b1;
    endfunction

    function automatic void predict_word(input in_item_t w);
        int p, d, k;
        bit found, pushed;
        case (w.kind)
            KIND_RX: begin
                if (rx_cnt >= RX_DEPTH) begin
                    add_word(CODE_ACK, 8'h00, 1'b0, '0, 1'b1);
                end else begin
                    pushed = echo_push(w.data_byte);
                    if (w.data_byte == bs) begin
                        if (rx_cnt > 0) begin
                            rx_cnt--;
                            rx_wr = (rx_wr == 0) ? RX_DEPTH - 1 : rx_wr - 1;
                        end
                    end else begin
                        rx_ring[rx_wr] = w.data_byte;
                        rx_wr = rx_next(rx_wr);
                        rx_cnt++;
                        if (w.data_byte == delim && lines < int'(LINE_MAX)) lines++;
                    end
                    add_word(CODE_ACK, 8'h00, 1'b1, '0, 1'b1);
                end
            end
            KIND_TX_TICK: begin
                if (tx_cnt == 0) begin
                    add_word(CODE_ACK, 8'h00, 1'b0, '0, 1'b1);
                end else begin
                    add_word(CODE_TX_BYTE, tx_ring[tx_rd], 1'b0, '0, 1'b1);
                    tx_rd = tx_next(tx_rd);
                    tx_cnt--;
                end
            end
            KIND_PUT: begin
                pushed = echo_push(w.data_byte);
                add_word(CODE_ACK, 8'h00, pushed, '0, 1'b1);
            end
            KIND_GET_LINE: begin
                if (lines == 0) begin
                    add_word(CODE_NO_LINE, 8'h00, 1'b0, '0, 1'b1);
                end else begin
                    p = rx_rd;
                    d = 0;
                    found = 1'b0;
                    while (d < rx_cnt && !found) begin
                        if (rx_ring[p] == delim) begin
                            found = 1'b1;
                        end else begin
                            p = rx_next(p);
                            d++;
                        end
                    end
                    if (!found) begin
                        // count says a line is there but the delimiter was erased
                        rx_rd = rx_wr;
                        rx_cnt = 0;
                        add_word(CODE_NO_LINE, 8'h00, 1'b0, '0, 1'b1);
                    end else begin
                        for (k = 0; k < d; k++) begin
                            add_word(CODE_LINE_BYTE, rx_ring[rx_rd], 1'b0, '0, 1'b0);
                            rx_rd = rx_next(rx_rd);
                        end
                        rx_rd = rx_next(rx_rd);
                        rx_cnt -= d + 1;
                        lines--;
                        add_word(CODE_LINE_END, 8'h00, 1'b0, LEN_W'(d), 1'b1);
                    end
                end
            end
            KIND_CLEAR: begin
                rx_cnt = 0;
                rx_wr = 0;
                rx_rd = 0;
                lines = 0;
                add_word(CODE_ACK, 8'h00, 1'b1, '0, 1'b1);
            end
            default: begin
                add_word(CODE_ACK, 8'h00, 1'b0, '0, 1'b1);
            end
        endcase
    endfunction

    // content byte that is neither delimiter nor backspace
    function automatic logic [7:0] typed_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while (b == delim || b == bs);
        return b;
    endfunction

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("uart_line_edit_buffer test failed");
            $finish;
        end
    end

    // receiver: random ready, with a long hold-off on request
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else if (hold_asked != hold_served) begin
            hold_served <= hold_asked;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (steady) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                $error("unexpected result word: code %0d byte %0h", m_data.code, m_data.out_byte);
                failures++;
            end else begin
                want = expected_words.pop_front();
                if (m_data.code !== want.code) begin
                    $error("code: expected %0d, actual %0d", want.code, m_data.code);
                    failures++;
                end
                if (m_data.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %0h, actual %0h", want.out_byte, m_data.out_byte);
                    failures++;
                end
                if (m_data.accepted !== want.accepted) begin
                    $error("accepted: expected %0d, actual %0d", want.accepted, m_data.accepted);
                    failures++;
                end
                if (m_data.line_length !== want.line_length) begin
                    $error("line_length: expected %0d, actual %0d",
                           want.line_length, m_data.line_length);
                    failures++;
                end
                if (m_data.last !== want.last) begin
                    $error("last: expected %0d, actual %0d", want.last, m_data.last);
                    failures++;
                end
            end
        end
    end

    // valid stays up after a word unless this call decides to idle
    task automatic send_word(input logic [2:0] kind, input logic [7:0] value);
        in_item_t w;
        w.kind = kind;
        w.data_byte = value;
        s_data <= w;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        predict_word(w);
        item_count++;
        if (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_DELIMITER: delim = value;
            CFG_BACKSPACE: bs = value;
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [7:0] new_delim, input logic [7:0] new_bs);
        wait_drained();
        write_reg(CFG_DELIMITER, new_delim);
        write_reg(CFG_BACKSPACE, new_bs);
        // spare indexes must change nothing
        write_reg(CFG_SPARE_A, 8'($urandom_range(255)));
        write_reg(CFG_SPARE_B, 8'($urandom_range(255)));
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed();
        send_word(KIND_TX_TICK, 8'h00);      // empty transmit ring
        send_word(KIND_GET_LINE, 8'h00);     // no line pending
        send_word(KIND_RX, bs);              // erase on empty ring: echo only
        send_word(KIND_RX, 8'h00);
        send_word(KIND_RX, 8'hFF);
        send_word(KIND_RX, bs);
        send_word(KIND_RX, 8'h41);
        send_word(KIND_RX, delim);
        send_word(KIND_GET_LINE, 8'hFF);
        send_word(KIND_TX_TICK, 8'hFF);
        send_word(KIND_PUT, 8'hFF);
        send_word(KIND_PUT, 8'h00);
        send_word(3'($urandom_range(6, KIND_CLEAR + 1)), 8'h00);
        send_word(3'($urandom_range(7, 6)), 8'hFF);
        send_word(KIND_RX, 8'h58);
        send_word(KIND_RX, delim);
        send_word(KIND_RX, bs);              // erases the delimiter, count stays
        send_word(KIND_GET_LINE, 8'h00);     // stale count: ring discarded
        send_word(KIND_GET_LINE, 8'h00);
        send_word(KIND_RX, 8'h31);
        send_word(KIND_RX, delim);
        send_word(KIND_GET_LINE, 8'h00);
        send_word(KIND_CLEAR, 8'hFF);
        send_word(KIND_GET_LINE, 8'h00);
    endtask

    // two full rings of delimiters, 128 in all: count must stop at its ceiling, not wrap
    // to zero; also covers refusal on a full ring and echo drops on a full tx ring
    task automatic test_line_count_ceiling();
        int k;
        program_regs(CEIL_DELIM, BS_RESET);
        for (k = 0; k < RX_DEPTH; k++) send_word(KIND_RX, CEIL_DELIM);
        send_word(KIND_RX, CEIL_DELIM);      // refused while full
        send_word(KIND_RX, bs);              // refused while full, nothing erased
        send_word(KIND_PUT, 8'($urandom_range(255)));
        // no delimiter stored under the new setting: ring discarded, count kept
        program_regs(CEIL_OTHER, BS_RESET);
        send_word(KIND_GET_LINE, 8'h00);
        program_regs(CEIL_DELIM, BS_RESET);
        for (k = 0; k < RX_DEPTH; k++) send_word(KIND_RX, CEIL_DELIM);
        send_word(KIND_GET_LINE, 8'h00);     // empty line
        send_word(KIND_CLEAR, 8'h00);
    endtask

    task automatic test_random_lines(input int n_items);
        int stop_at, len, k, roll;
        stop_at = item_count + n_items;
        while (item_count < stop_at) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(62) : $urandom_range(10);
            for (k = 0; k < len; k++) begin
                roll = $urandom_range(99);
                if (roll < 8) send_word(KIND_RX, bs);
                else if (roll < 12) send_word(KIND_TX_TICK, 8'($urandom_range(255)));
                else if (roll < 15) send_word(KIND_PUT, 8'($urandom_range(255)));
                else if (roll < 17)
                    send_word(3'($urandom_range(7, KIND_CLEAR + 1)), 8'($urandom_range(255)));
                else if (roll < 22) send_word(KIND_RX, 8'($urandom_range(255)));
                else send_word(KIND_RX, typed_byte());
            end
            if ($urandom_range(9) != 0) send_word(KIND_RX, delim);
            if ($urandom_range(9) < 7) send_word(KIND_GET_LINE, 8'($urandom_range(255)));
            repeat ($urandom_range(len + 2)) send_word(KIND_TX_TICK, 8'($urandom_range(255)));
            if ($urandom_range(29) == 0) send_word(KIND_CLEAR, 8'($urandom_range(255)));
        end
    endtask

    task automatic test_backpressure();
        int k;
        hold_asked++;
        for (k = 0; k < 12; k++) send_word(KIND_RX, typed_byte());
        send_word(KIND_RX, delim);
        send_word(KIND_GET_LINE, 8'h00);
        for (k = 0; k < 6; k++) send_word(KIND_TX_TICK, 8'h00);
    endtask

    initial begin
        logic [7:0] shared;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_line_count_ceiling();

        program_regs(8'h00, 8'hFF);
        steady = 1'b1;
        test_random_lines(15);
        steady = 1'b0;
        test_backpressure();

        // delimiter and backspace equal: erase wins
        shared = 8'($urandom_range(255));
        program_regs(shared, shared);
        test_random_lines(10);

        program_regs(DELIM_RESET, BS_RESET);
        test_random_lines(10);

        wait_drained();
        repeat (20) @(posedge aclk);
        if (failures == 0) begin
            $display("uart_line_edit_buffer test passed");
        end else begin
            $display("uart_line_edit_buffer test failed");
        end
        $finish;
    end

endmodule
